@@ hw/rtl/imc_pkg.sv @@
// ----------------------------------------------------------------------------
// imc_pkg: shared types and constants of the IMU motion conditioner
// Field widths, command and register codes, sequencer states, saturation.
// ----------------------------------------------------------------------------
package imc_pkg;

    // field widths
    localparam int CMD_W       = 2;
    localparam int RAW_W       = 16;
    localparam int AOUT_W      = 24;
    localparam int ROUT_W      = 26;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int WEIGHT_W    = 9;

    // state widths
    localparam int ACC_W       = 24;
    localparam int RATE_W      = 25;
    localparam int OFF_W       = 24;
    localparam int SUM_W       = 23;
    localparam int CNT_W       = 7;

    // shared multiplier and divider datapath
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 28;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int U_W         = 26;   // dividend width of the reciprocal divider
    localparam int A_W         = U_W + 1;
    localparam int LOAD_W      = U_W + 2;
    localparam int REM_W       = 8;
    localparam int QD_W        = U_W + REM_W;
    localparam int SAT_W       = 40;

    // scaling
    localparam int WEIGHT_FRAC    = 8;
    localparam int WEIGHT_ONE     = 1 << WEIGHT_FRAC;
    localparam int WEIGHT_HALF    = WEIGHT_ONE / 2;
    localparam int WEIGHT_RESET   = 38;
    localparam int ACC_SCALE_LOG2 = 8;    // Q.22 g from 16384 counts per g
    localparam int RATE_OUT_FRAC  = 16;
    localparam int RATE_DIV       = 131;  // gyro counts per deg/s

    // command codes
    localparam logic [CMD_W-1:0] CMD_MOTION = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALIB  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TARE   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMU_PRESENT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_UPD,
        ST_LOAD,
        ST_MUL1,
        ST_QUO1,
        ST_REM,
        ST_MUL2,
        ST_QUO2,
        ST_CAL_SUM,
        ST_ACC_OUT,
        ST_EMIT
    } state_t;

    typedef enum logic {
        DIV_RATE,
        DIV_CAL
    } div_kind_t;

    function automatic logic signed [SAT_W-1:0] sat_to(input logic signed [SAT_W-1:0] v,
                                                       input int unsigned w);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = signed'((SAT_W'(1) << (w - 1)) - SAT_W'(1));
        lo = ~hi;
        if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/imc_sample_if.sv @@
// ----------------------------------------------------------------------------
// imc_sample_if: raw IMU sample request channel
// Valid/ready handshake carrying the command and six raw axis readings.
// ----------------------------------------------------------------------------
interface imc_sample_if;
    import imc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [RAW_W-1:0] accel_x_raw;
    logic signed [RAW_W-1:0] accel_y_raw;
    logic signed [RAW_W-1:0] accel_z_raw;
    logic signed [RAW_W-1:0] rate_x_raw;
    logic signed [RAW_W-1:0] rate_y_raw;
    logic signed [RAW_W-1:0] rate_z_raw;

    modport source (
        output valid, command, accel_x_raw, accel_y_raw, accel_z_raw,
               rate_x_raw, rate_y_raw, rate_z_raw,
        input  ready
    );

    modport sink (
        input  valid, command, accel_x_raw, accel_y_raw, accel_z_raw,
               rate_x_raw, rate_y_raw, rate_z_raw,
        output ready
    );
endinterface

@@ hw/rtl/imc_result_if.sv @@
// ----------------------------------------------------------------------------
// imc_result_if: conditioned motion result channel
// Valid/ready handshake carrying scaled acceleration and rotation rate.
// ----------------------------------------------------------------------------
interface imc_result_if;
    import imc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [AOUT_W-1:0] accel_x_out;
    logic signed [AOUT_W-1:0] accel_y_out;
    logic signed [AOUT_W-1:0] accel_z_out;
    logic signed [ROUT_W-1:0] rate_x_out;
    logic signed [ROUT_W-1:0] rate_y_out;
    logic signed [ROUT_W-1:0] rate_z_out;

    modport source (
        output valid, accel_x_out, accel_y_out, accel_z_out,
               rate_x_out, rate_y_out, rate_z_out,
        input  ready
    );

    modport sink (
        input  valid, accel_x_out, accel_y_out, accel_z_out,
               rate_x_out, rate_y_out, rate_z_out,
        output ready
    );
endinterface

@@ hw/rtl/imu_motion_conditioner_top.sv @@
// ----------------------------------------------------------------------------
// imu_motion_conditioner_top: IMU sample filter with gyro bias calibration
// Shared-multiplier sequencer: low-pass per axis, bias mean, tare and scaling.
// ----------------------------------------------------------------------------
// Motion sample: FILT, UPD per axis; LOAD, MUL1, QUO1, REM, MUL2, QUO2 per gyro lane;
//   ACC_OUT, EMIT. The single multiplier runs 6 filter products then 3 reciprocal
//   divides. New samples are taken only in IDLE. Sensor absent: zero result via EMIT.
// Tare, ignored: back to IDLE. Calibration: CAL_SUM, plus divides on the last sample.
// Reset (async, active low): filter state, offsets, sums, tare cleared;
//   imu_present = 0, smoothing_weight = 38. No clearing pass.
module imu_motion_conditioner_top #(
    parameter int CAL_SAMPLES = 50,
    parameter int FRAC_BITS   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [imc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imc_pkg::CFG_DATA_W-1:0]    cfg_data,
    imc_sample_if.sink                        sample,
    imc_result_if.source                      result
);
    import imc_pkg::*;

    // ------------------------------------------------------------------------
    // Derived constants
    // ------------------------------------------------------------------------
    // Filter difference width: raw scaled by 2^FRAC_BITS against the state.
    localparam int XW    = (RAW_W + FRAC_BITS > RATE_W) ? RAW_W + FRAC_BITS : RATE_W;
    localparam int DLT_W = XW + 2;

    // Accel output scale by 2^(8-FRAC_BITS), rounded when it is a right shift.
    localparam int ACC_LSH = (FRAC_BITS <= ACC_SCALE_LOG2) ? ACC_SCALE_LOG2 - FRAC_BITS : 0;
    localparam int ACC_RSH = (FRAC_BITS > ACC_SCALE_LOG2) ? FRAC_BITS - ACC_SCALE_LOG2 : 0;
    localparam int ACC_RND = (1 << ACC_RSH) >> 1;

    // Rate output: round(f*2^16 / (131*2^F)) = floor((f*2^RS + 65) / 131).
    localparam int RS       = RATE_OUT_FRAC - FRAC_BITS;
    localparam int RND_RATE = RATE_DIV / 2;

    // Reciprocal divider. floor(u/d) = (u * ceil(2^K/d)) >> K exact for
    // u < 2^U_W when K = U_W + clog2(d).
    localparam int CAL2  = 2 * CAL_SAMPLES;
    localparam int K_R   = U_W + $clog2(RATE_DIV);
    localparam int K_C1  = U_W + $clog2(CAL_SAMPLES);
    localparam int K_C2  = U_W + $clog2(CAL2);
    localparam logic [63:0] RR_64  = ((64'd1 << K_R)  + 64'(RATE_DIV) - 64'd1) / 64'(RATE_DIV);
    localparam logic [63:0] RC1_64 = ((64'd1 << K_C1) + 64'(CAL_SAMPLES) - 64'd1)
                                     / 64'(CAL_SAMPLES);
    localparam logic [63:0] RC2_64 = ((64'd1 << K_C2) + 64'(CAL2) - 64'd1) / 64'(CAL2);
    localparam logic [MUL_B_W-1:0] RB_RATE = RR_64[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] RB_CAL1 = RC1_64[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] RB_CAL2 = RC2_64[MUL_B_W-1:0];

    // Bias that makes a signed dividend non-negative: a multiple of d.
    localparam int OFFK_RATE = ((1 << (RATE_W - 1)) + RATE_DIV - 1) / RATE_DIV;
    localparam int OFFK_CAL  = ((1 << (SUM_W - 1)) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic signed [LOAD_W-1:0] OFFV_RATE = LOAD_W'(RATE_DIV * OFFK_RATE);
    localparam logic signed [LOAD_W-1:0] OFFV_CAL  = LOAD_W'(CAL_SAMPLES * OFFK_CAL);
    localparam logic [QD_W-1:0]          D_RATE_Q  = QD_W'(RATE_DIV);
    localparam logic [QD_W-1:0]          D_CAL_Q   = QD_W'(CAL_SAMPLES);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t    state_reg, state_next;
    logic [2:0] ax_reg, ax_next;              // 0..2 accel, 3..5 gyro
    div_kind_t kind_reg, kind_next;

    logic                 present_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic                 out_valid_reg;

    logic signed [ACC_W-1:0]  acc_f_reg    [3];
    logic signed [RATE_W-1:0] rate_f_reg   [3];
    logic signed [OFF_W-1:0]  rate_off_reg [3];
    logic signed [SUM_W-1:0]  cal_sum_reg  [3];
    logic [CNT_W-1:0]         cal_cnt_reg;
    logic signed [ACC_W-1:0]  tare_reg     [2];

    logic signed [RAW_W-1:0]  raw_reg      [6];
    logic signed [PROD_W-1:0] prod_reg;
    logic [U_W-1:0]           u_reg;
    logic [U_W-1:0]           q_reg;
    logic signed [A_W-1:0]    a_reg;
    logic signed [AOUT_W-1:0] res_acc_reg  [3];
    logic signed [ROUT_W-1:0] res_rate_reg [3];
    logic signed [AOUT_W-1:0] out_acc_reg  [3];
    logic signed [ROUT_W-1:0] out_rate_reg [3];

    // ------------------------------------------------------------------------
    // Control signals
    // ------------------------------------------------------------------------
    logic accept;
    logic emit_fire;
    logic sample_ready;
    logic cal_done;
    logic last_div_ax;

    assign accept      = sample.valid && sample_ready;
    assign cal_done    = (cal_cnt_reg == CNT_W'(CAL_SAMPLES - 1));
    assign last_div_ax = (ax_reg == 3'd2);

    // next state
    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    priority if (sample.command == CMD_MOTION && !present_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (!present_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (sample.command == CMD_MOTION)
                    begin
                        state_next = ST_FILT;
                        ax_next    = 3'd0;
                    end
                    else if (sample.command == CMD_CALIB)
                    begin
                        state_next = ST_CAL_SUM;
                    end
                    else
                    begin
                        // tare is taken at once; unused code is dropped
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FILT:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (ax_reg == 3'd5)
                begin
                    state_next = ST_LOAD;
                    ax_next    = 3'd0;
                    kind_next  = DIV_RATE;
                end
                else
                begin
                    state_next = ST_FILT;
                    ax_next    = ax_reg + 3'd1;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_QUO1;
            end
            ST_QUO1:
            begin
                state_next = ST_REM;
            end
            ST_REM:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_QUO2;
            end
            ST_QUO2:
            begin
                if (!last_div_ax)
                begin
                    state_next = ST_LOAD;
                    ax_next    = ax_reg + 3'd1;
                end
                else if (kind_reg == DIV_RATE)
                begin
                    state_next = ST_ACC_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CAL_SUM:
            begin
                if (cal_done)
                begin
                    state_next = ST_LOAD;
                    ax_next    = 3'd0;
                    kind_next  = DIV_CAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC_OUT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        sample_ready = 1'b0;
        emit_fire    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
            end
            ST_EMIT:
            begin
                // output register is free or is being taken this cycle
                emit_fire = !out_valid_reg || result.ready;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    assign sample.ready = sample_ready;

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    logic [WEIGHT_W-1:0]      w_eff;
    logic [1:0]               fidx;
    logic                     is_rate;
    logic signed [RAW_W-1:0]  raw_sel;
    logic signed [DLT_W-1:0]  x_s;
    logic signed [DLT_W-1:0]  f_s;
    logic signed [DLT_W-1:0]  dlt_s;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] step_s;
    logic signed [SAT_W-1:0]  upd_s;
    logic signed [SAT_W-1:0]  upd_sat;
    logic signed [LOAD_W-1:0] load_s;
    logic [U_W-1:0]           quo1;
    logic [QD_W-1:0]          qd;
    logic [REM_W-1:0]         rem;
    logic [U_W-1:0]           u2;
    logic signed [A_W-1:0]    a_next;
    logic [U_W-1:0]           quo2;
    logic signed [SAT_W-1:0]  fin_s;
    logic signed [SAT_W-1:0]  fin_sat;
    logic signed [ACC_W-1:0]  tare_ext [3];
    logic signed [SAT_W-1:0]  acc_d    [3];
    logic signed [SAT_W-1:0]  acc_sat  [3];
    logic signed [SAT_W-1:0]  sum_s    [3];
    logic signed [SAT_W-1:0]  sum_sat  [3];

    // weight 0 acts as 1, anything above 256 as 256
    always_comb
    begin
        priority if (weight_reg == '0)
        begin
            w_eff = WEIGHT_W'(1);
        end
        else if (weight_reg > WEIGHT_W'(WEIGHT_ONE))
        begin
            w_eff = WEIGHT_W'(WEIGHT_ONE);
        end
        else
        begin
            w_eff = weight_reg;
        end
    end

    // axis operand select for the filter step
    always_comb
    begin
        is_rate = (ax_reg >= 3'd3);
        fidx    = is_rate ? 2'(ax_reg - 3'd3) : ax_reg[1:0];
        raw_sel = raw_reg[ax_reg];
        if (is_rate)
        begin
            f_s = DLT_W'(rate_f_reg[fidx]);
            x_s = (DLT_W'(raw_sel) <<< FRAC_BITS) - DLT_W'(rate_off_reg[fidx]);
        end
        else
        begin
            f_s = DLT_W'(acc_f_reg[fidx]);
            x_s = DLT_W'(raw_sel) <<< FRAC_BITS;
        end
        dlt_s = x_s - f_s;
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            ST_FILT:
            begin
                mul_a = MUL_A_W'(dlt_s);
                mul_b = MUL_B_W'(signed'({1'b0, w_eff}));
            end
            ST_MUL1:
            begin
                mul_a = MUL_A_W'(signed'({1'b0, u_reg}));
                mul_b = signed'((kind_reg == DIV_RATE) ? RB_RATE : RB_CAL1);
            end
            ST_MUL2:
            begin
                mul_a = MUL_A_W'(signed'({1'b0, u_reg}));
                mul_b = signed'((kind_reg == DIV_RATE) ? RB_RATE : RB_CAL2);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // f + floor((w*(x-f) + 128) / 256), saturated to the state width
    always_comb
    begin
        step_s  = (prod_reg + PROD_W'(WEIGHT_HALF)) >>> WEIGHT_FRAC;
        upd_s   = SAT_W'(f_s) + SAT_W'(step_s);
        upd_sat = sat_to(upd_s, is_rate ? RATE_W : ACC_W);
    end

    // divider steps
    always_comb
    begin
        if (kind_reg == DIV_RATE)
        begin
            load_s = LOAD_W'(rate_f_reg[ax_reg[1:0]]) + OFFV_RATE;
            quo1   = U_W'(prod_reg >> K_R);
            qd     = QD_W'(q_reg) * D_RATE_Q;
            rem    = REM_W'(QD_W'(u_reg) - qd);
            u2     = (U_W'(rem) << RS) + U_W'(RND_RATE);
            a_next = signed'(q_reg) - A_W'(OFFK_RATE);
            quo2   = U_W'(prod_reg >> K_R);
            fin_s  = (SAT_W'(a_reg) <<< RS) + SAT_W'(quo2);
            fin_sat = sat_to(fin_s, ROUT_W);
        end
        else
        begin
            load_s = LOAD_W'(cal_sum_reg[ax_reg[1:0]]) + OFFV_CAL;
            quo1   = U_W'(prod_reg >> K_C1);
            qd     = QD_W'(q_reg) * D_CAL_Q;
            rem    = REM_W'(QD_W'(u_reg) - qd);
            u2     = (U_W'(rem) << (FRAC_BITS + 1)) + U_W'(CAL_SAMPLES);
            a_next = signed'(q_reg) - A_W'(OFFK_CAL);
            quo2   = U_W'(prod_reg >> K_C2);
            fin_s  = (SAT_W'(a_reg) <<< FRAC_BITS) + SAT_W'(quo2);
            fin_sat = sat_to(fin_s, OFF_W);
        end
    end

    // accel output scale and calibration accumulate, three lanes each
    always_comb
    begin
        tare_ext[0] = tare_reg[0];
        tare_ext[1] = tare_reg[1];
        tare_ext[2] = '0;            // Z carries no tare
        for (int i = 0; i < 3; i++)
        begin
            acc_d[i]   = SAT_W'(acc_f_reg[i]) - SAT_W'(tare_ext[i]);
            acc_d[i]   = ((acc_d[i] <<< ACC_LSH) + SAT_W'(ACC_RND)) >>> ACC_RSH;
            acc_sat[i] = sat_to(acc_d[i], AOUT_W);
            sum_s[i]   = SAT_W'(cal_sum_reg[i]) + SAT_W'(raw_reg[3 + i]);
            sum_sat[i] = sat_to(sum_s[i], SUM_W);
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ax_reg        <= 3'd0;
            kind_reg      <= DIV_RATE;
            present_reg   <= 1'b0;
            weight_reg    <= WEIGHT_W'(WEIGHT_RESET);
            out_valid_reg <= 1'b0;
            cal_cnt_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                acc_f_reg[i]    <= '0;
                rate_f_reg[i]   <= '0;
                rate_off_reg[i] <= '0;
                cal_sum_reg[i]  <= '0;
            end
            tare_reg[0] <= '0;
            tare_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            kind_reg  <= kind_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMU_PRESENT:      present_reg <= cfg_data[0];
                    REG_SMOOTHING_WEIGHT: weight_reg  <= cfg_data[WEIGHT_W-1:0];
                endcase
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // tare capture happens in the accept cycle
            if (accept && present_reg && sample.command == CMD_TARE)
            begin
                tare_reg[0] <= acc_f_reg[0];
                tare_reg[1] <= acc_f_reg[1];
            end

            if (state_reg == ST_UPD)
            begin
                if (is_rate)
                begin
                    rate_f_reg[fidx] <= upd_sat[RATE_W-1:0];
                end
                else
                begin
                    acc_f_reg[fidx] <= upd_sat[ACC_W-1:0];
                end
            end

            if (state_reg == ST_CAL_SUM)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cal_sum_reg[i] <= sum_sat[i][SUM_W-1:0];
                end
                cal_cnt_reg <= cal_done ? '0 : cal_cnt_reg + CNT_W'(1);
            end

            if (state_reg == ST_QUO2 && kind_reg == DIV_CAL)
            begin
                rate_off_reg[ax_reg[1:0]] <= fin_sat[OFF_W-1:0];
                if (last_div_ax)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cal_sum_reg[i] <= '0;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0] <= sample.accel_x_raw;
            raw_reg[1] <= sample.accel_y_raw;
            raw_reg[2] <= sample.accel_z_raw;
            raw_reg[3] <= sample.rate_x_raw;
            raw_reg[4] <= sample.rate_y_raw;
            raw_reg[5] <= sample.rate_z_raw;
            // absent sensor: the result is all zero
            for (int i = 0; i < 3; i++)
            begin
                res_acc_reg[i]  <= '0;
                res_rate_reg[i] <= '0;
            end
        end

        if (state_reg == ST_FILT || state_reg == ST_MUL1 || state_reg == ST_MUL2)
        begin
            prod_reg <= prod_next;
        end

        if (state_reg == ST_LOAD)
        begin
            u_reg <= load_s[U_W-1:0];
        end

        if (state_reg == ST_QUO1)
        begin
            q_reg <= quo1;
        end

        if (state_reg == ST_REM)
        begin
            u_reg <= u2;
            a_reg <= a_next;
        end

        if (state_reg == ST_QUO2 && kind_reg == DIV_RATE)
        begin
            res_rate_reg[ax_reg[1:0]] <= fin_sat[ROUT_W-1:0];
        end

        if (state_reg == ST_ACC_OUT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_acc_reg[i] <= acc_sat[i][AOUT_W-1:0];
            end
        end

        if (emit_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_acc_reg[i]  <= res_acc_reg[i];
                out_rate_reg[i] <= res_rate_reg[i];
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.accel_x_out = out_acc_reg[0];
    assign result.accel_y_out = out_acc_reg[1];
    assign result.accel_z_out = out_acc_reg[2];
    assign result.rate_x_out  = out_rate_reg[0];
    assign result.rate_y_out  = out_rate_reg[1];
    assign result.rate_z_out  = out_rate_reg[2];

`ifndef NO_ASSERTIONS
    // calibration count always wraps before reaching the sample count
    a_cal_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_cnt_reg < CNT_W'(CAL_SAMPLES))
        else $error("calibration count out of range");

    // a granted emit always leaves a valid result
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!out_valid_reg || result.ready)) |=> out_valid_reg)
        else $error("emitted result not valid");

    // divider works on the three gyro lanes only
    a_div_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD || state_reg == ST_MUL1 || state_reg == ST_QUO1 ||
         state_reg == ST_REM || state_reg == ST_MUL2 || state_reg == ST_QUO2)
        |-> ax_reg <= 3'd2)
        else $error("divider axis out of range");

    // completing calibration clears sums and count
    a_cal_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUO2 && kind_reg == DIV_CAL && last_div_ax)
        |=> (cal_cnt_reg == '0 && cal_sum_reg[0] == '0 && cal_sum_reg[1] == '0 &&
             cal_sum_reg[2] == '0))
        else $error("calibration state not cleared");
`endif

endmodule
